>>> rtl/vil_pkg.sv
// Shared types, constants and the liquid-water-content table generator
// for the column integrator. No dependencies.
package vil_pkg;

   localparam int LWC_TABLE_DEPTH_DEF = 961;

   localparam int LWC_W    = 20;   // g/m^3, 16 fraction bits
   localparam int ACC_W    = 48;   // g/m^2, 17 fraction bits
   localparam int VIL_W    = 22;   // g/m^2, 4 fraction bits
   localparam int HGT_W    = 16;
   localparam int DBZ_W    = 11;
   localparam int STAT_W   = 2;
   localparam int PROD_W   = 37;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 3;

   localparam int DBZ_LOW  = -400;
   localparam int DBZ_HIGH = 560;

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
   localparam logic [VIL_W-1:0] VIL_MAX = {VIL_W{1'b1}};

   // register index carried by paddr[2]
   localparam logic REG_GROUND_HEIGHT = 1'b0;

   typedef enum logic [STAT_W-1:0] {
      STATUS_WEATHER     = 2'd0,
      STATUS_NO_ECHO     = 2'd1,
      STATUS_UNAVAILABLE = 2'd2
   } status_type;

   localparam longint unsigned Q28_ONE     = 64'd268435456;
   localparam longint unsigned Q28_HALF    = 64'd134217728;
   localparam longint unsigned STEP_FACTOR = 64'd271990769;
   localparam longint unsigned LWC_SCALE   = 64'd22544384;

   // Table entry for address idx (address = clamped dBZ tenths + 400).
   // 10^((d+525)/175) is built as 10^q times a product of Q28 factors 10^(2^b/175).
   function automatic logic [LWC_W-1:0] lwc_entry(input int idx, input int depth);
      longint d;
      longint hi;
      longint unsigned u;
      longint unsigned q;
      longint unsigned r;
      longint unsigned m;
      longint unsigned f;
      longint unsigned t;
      longint unsigned p;
      longint unsigned val;
      int b;
      hi = longint'(DBZ_LOW + depth - 1);
      if (hi > DBZ_HIGH) hi = DBZ_HIGH;
      d = longint'(idx + DBZ_LOW);
      if (d > hi) d = hi;
      if (d < DBZ_LOW) d = DBZ_LOW;
      u = longint'(d + 525);
      q = u / 175;
      r = u % 175;
      m = Q28_ONE;
      f = STEP_FACTOR;
      for (b = 0; b < 8; b++) begin
         if (r[b]) m = (m * f + Q28_HALF) >> 28;
         f = (f * f + Q28_HALF) >> 28;
      end
      t = (LWC_SCALE * m + Q28_HALF) >> 28;
      p = 64'd1;
      for (b = 0; b < 8; b++) begin
         if (longint'(b) < longint'(q)) p = p * 64'd10;
      end
      val = (t * p + 64'd50000000) / 64'd100000000;
      return val[LWC_W-1:0];
   endfunction

endpackage

>>> rtl/vil_lwc_rom.sv
// Reflectivity to liquid water content lookup, registered read.
// Depends on vil_pkg for the entry generator.
module vil_lwc_rom
   import vil_pkg::*;
#(
   parameter int DEPTH  = LWC_TABLE_DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [LWC_W-1:0]  rd_data
);

   logic [LWC_W-1:0] rom_data [DEPTH];
   logic [LWC_W-1:0] rd_data_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_rom
      assign rom_data[i] = lwc_entry(i, DEPTH);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_data[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/vil_column_integrator.sv
// Column VIL integrator: 1 sample accepted per cycle while no column end is held up by rsp_stall.
// A result reaches rsp through the sample/ROM register, product stage,
// accumulate stage and output register, in that order.
// Only column results wait on rsp_stall; samples that end no column
// retire in the accumulate stage, so inputs keep flowing while a result waits.
// Synchronous reset clears all pipeline valids, column state and ground height.
module vil_column_integrator
   import vil_pkg::*;
#(
   parameter int LWC_TABLE_DEPTH = LWC_TABLE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // sample channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_observed,
   input  logic                    req_good,
   input  logic signed [DBZ_W-1:0] req_dbz_tenths,
   input  logic signed [HGT_W-1:0] req_height_m,
   input  logic                    req_last_sample,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [VIL_W-1:0]        rsp_vil_value,
   output logic [STAT_W-1:0]       rsp_column_status,
   // register port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_AW-1:0]       paddr,
   input  logic [CSR_DW-1:0]       pwdata,
   output logic [CSR_DW-1:0]       prdata,
   output logic                    pready
);

   localparam int ADDR_W  = $clog2(LWC_TABLE_DEPTH);
   localparam int HI_DBZ  = (DBZ_HIGH < DBZ_LOW + LWC_TABLE_DEPTH - 1) ?
                            DBZ_HIGH : DBZ_LOW + LWC_TABLE_DEPTH - 1;
   localparam logic signed [DBZ_W:0] CLAMP_HI  = (DBZ_W + 1)'(HI_DBZ);
   localparam logic signed [DBZ_W:0] CLAMP_LO  = (DBZ_W + 1)'(DBZ_LOW);
   localparam logic signed [DBZ_W:0] ADDR_BIAS = (DBZ_W + 1)'(-DBZ_LOW);

   // ---------------- register port ----------------
   logic signed [HGT_W-1:0] ground_ff;
   logic                    csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ground_ff <= '0;
      end else if (csr_wr && paddr[2] == REG_GROUND_HEIGHT) begin
         ground_ff <= pwdata[HGT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_GROUND_HEIGHT) begin
         prdata = {{(CSR_DW - HGT_W){ground_ff[HGT_W-1]}}, ground_ff};
      end
   end

   // ---------------- pipeline flow ----------------
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_free, s2_go, s2_free, s1_go, s1_free, s0_go, s0_free, accept;
   logic s1_last_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_go     = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_go     = s1_valid_ff && (!s1_last_ff || s2_free);
   assign s1_free   = !s1_valid_ff || s1_go;
   assign s0_go     = s0_valid_ff && s1_free;
   assign s0_free   = !s0_valid_ff || s0_go;
   assign accept    = req_valid && s0_free;
   assign req_stall = !s0_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept)     s0_valid_ff <= 1'b1;
         else if (s0_go) s0_valid_ff <= 1'b0;
         if (s0_go)      s1_valid_ff <= 1'b1;
         else if (s1_go) s1_valid_ff <= 1'b0;
         if (s1_go && s1_last_ff) s2_valid_ff <= 1'b1;
         else if (s2_go)          s2_valid_ff <= 1'b0;
         if (out_free)   rsp_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------- stage 0: sample register + table read ----------------
   logic signed [DBZ_W:0]   dbz_ext, dbz_clamp, addr_sum;
   logic [ADDR_W-1:0]       rom_addr;
   logic [LWC_W-1:0]        s0_lwc;
   logic                    s0_obs_ff, s0_good_ff, s0_last_ff;
   logic signed [HGT_W-1:0] s0_height_ff;

   always_comb begin
      dbz_ext = {req_dbz_tenths[DBZ_W-1], req_dbz_tenths};
      if (dbz_ext > CLAMP_HI)      dbz_clamp = CLAMP_HI;
      else if (dbz_ext < CLAMP_LO) dbz_clamp = CLAMP_LO;
      else                         dbz_clamp = dbz_ext;
      addr_sum = dbz_clamp + ADDR_BIAS;
   end

   assign rom_addr = addr_sum[ADDR_W-1:0];

   vil_lwc_rom #(
      .DEPTH  (LWC_TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_rom (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rom_addr),
      .rd_data (s0_lwc)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_obs_ff    <= req_observed;
         s0_good_ff   <= req_good;
         s0_height_ff <= req_height_m;
         s0_last_ff   <= req_last_sample;
      end
   end

   // ---------------- stage 1: top-of-column state, products ----------------
   logic signed [HGT_W-1:0] top_height_ff, top_height_in;
   logic [LWC_W-1:0]        top_lwc_ff, top_lwc_in;
   logic                    have_top_ff, have_top_in;
   logic                    any_obs_ff, any_obs_in;

   logic                    obs_good;
   logic signed [HGT_W:0]   drop_full, ext_diff;
   logic [HGT_W-1:0]        drop_mag;
   logic [LWC_W:0]          lwc_pair;
   logic [PROD_W-1:0]       seg_prod, seg_sel;
   logic [PROD_W-2:0]       ext_prod;
   logic [PROD_W-1:0]       ext_sel;
   logic signed [HGT_W-1:0] th_new;
   logic [LWC_W-1:0]        tl_new;
   logic                    ht_new, ao_new;

   logic [PROD_W-1:0]       s1_seg_ff, s1_ext_ff;
   logic                    s1_have_ff, s1_obs_ff;

   always_comb begin
      obs_good  = s0_obs_ff && s0_good_ff;
      drop_full = {top_height_ff[HGT_W-1], top_height_ff}
                - {s0_height_ff[HGT_W-1], s0_height_ff};
      // rising beam counts as no drop
      drop_mag  = drop_full[HGT_W] ? '0 : drop_full[HGT_W-1:0];
      lwc_pair  = {1'b0, top_lwc_ff} + {1'b0, s0_lwc};
      seg_prod  = lwc_pair * drop_mag;
      seg_sel   = (obs_good && have_top_ff) ? seg_prod : '0;

      th_new = obs_good ? s0_height_ff : top_height_ff;
      tl_new = obs_good ? s0_lwc : top_lwc_ff;
      ht_new = have_top_ff || obs_good;
      ao_new = any_obs_ff || s0_obs_ff;

      // extension of the lowest good content down to the floor
      ext_diff = {th_new[HGT_W-1], th_new} - {ground_ff[HGT_W-1], ground_ff};
      ext_prod = tl_new * ext_diff[HGT_W-1:0];
      ext_sel  = (s0_last_ff && ht_new && !ext_diff[HGT_W] && (|ext_diff[HGT_W-1:0]))
               ? {ext_prod, 1'b0} : '0;

      if (s0_last_ff) begin
         top_height_in = '0;
         top_lwc_in    = '0;
         have_top_in   = 1'b0;
         any_obs_in    = 1'b0;
      end else begin
         top_height_in = th_new;
         top_lwc_in    = tl_new;
         have_top_in   = ht_new;
         any_obs_in    = ao_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_height_ff <= '0;
         top_lwc_ff    <= '0;
         have_top_ff   <= 1'b0;
         any_obs_ff    <= 1'b0;
      end else if (s0_go) begin
         top_height_ff <= top_height_in;
         top_lwc_ff    <= top_lwc_in;
         have_top_ff   <= have_top_in;
         any_obs_ff    <= any_obs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_go) begin
         s1_seg_ff  <= seg_sel;
         s1_ext_ff  <= ext_sel;
         s1_last_ff <= s0_last_ff;
         s1_have_ff <= ht_new;
         s1_obs_ff  <= ao_new;
      end
   end

   // ---------------- stage 2: accumulate ----------------
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W+1:0]  acc_sum;
   logic [ACC_W-1:0]  acc_sat;
   logic [ACC_W-1:0]  s2_sum_ff;
   status_type        s2_status_ff, s1_status;

   always_comb begin
      // both adds saturate at the same ceiling, so one clamp covers them
      acc_sum = {2'b00, acc_ff}
              + {{(ACC_W + 2 - PROD_W){1'b0}}, s1_seg_ff}
              + {{(ACC_W + 2 - PROD_W){1'b0}}, s1_ext_ff};
      acc_sat = (acc_sum > {2'b00, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];
      acc_in  = s1_last_ff ? '0 : acc_sat;
      if (s1_have_ff)     s1_status = STATUS_WEATHER;
      else if (s1_obs_ff) s1_status = STATUS_NO_ECHO;
      else                s1_status = STATUS_UNAVAILABLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (s1_go) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_last_ff) begin
         s2_sum_ff    <= s1_have_ff ? acc_sat : '0;
         s2_status_ff <= s1_status;
      end
   end

   // ---------------- stage 3: round to 4 fraction bits, output register ----
   logic [ACC_W:0]          rnd_sum;
   logic [ACC_W-13:0]       vil_full;
   logic [VIL_W-1:0]        vil_in, rsp_vil_ff;
   logic [STAT_W-1:0]       rsp_status_ff;

   always_comb begin
      rnd_sum  = {1'b0, s2_sum_ff} + (ACC_W + 1)'(4096);
      vil_full = rnd_sum[ACC_W:13];
      vil_in   = (|vil_full[ACC_W-13:VIL_W]) ? VIL_MAX : vil_full[VIL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         rsp_vil_ff    <= vil_in;
         rsp_status_ff <= s2_status_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vil_value     = rsp_vil_ff;
   assign rsp_column_status = rsp_status_ff;

   // ---------------- checks ----------------
   a_no_weather_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_column_status != STATUS_WEATHER |-> rsp_vil_value == '0)
      else $error("VIL nonzero on a column without weather");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff |=> acc_ff == '0)
      else $error("accumulator not cleared after column end");

   a_top_cleared: assert property (@(posedge clock) disable iff (reset)
      s0_go && s0_last_ff |=> !have_top_ff && !any_obs_ff)
      else $error("column state not cleared after column end");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_go |=> s2_valid_ff && $stable(s2_sum_ff))
      else $error("pending result overwritten");

endmodule

>>> verif/vil_column_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the column integrator: watches the sample, result and register
// ports, predicts each column's VIL and status, and compares. Uses vil_pkg.
module vil_column_checker
   import vil_pkg::*;
#(
   parameter int TABLE_DEPTH = LWC_TABLE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic                    req_observed,
   input  logic                    req_good,
   input  logic signed [DBZ_W-1:0] req_dbz_tenths,
   input  logic signed [HGT_W-1:0] req_height_m,
   input  logic                    req_last_sample,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [VIL_W-1:0]        rsp_vil_value,
   input  logic [STAT_W-1:0]       rsp_column_status,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_AW-1:0]       paddr,
   input  logic [CSR_DW-1:0]       pwdata,
   input  logic                    pready,
   output int                      mismatch_count,
   output int                      open_columns,
   output int                      columns_checked
);

   localparam longint unsigned UNIT_Q28   = 64'd1 << 28;
   localparam longint unsigned HALF_Q28   = 64'd1 << 27;
   localparam longint unsigned DBZ_STEP   = 64'd271990769;   // 10^(1/175), Q28
   localparam longint unsigned LWC_GAIN   = 64'd22544384;
   localparam longint unsigned ACC_CEIL   = (64'd1 << ACC_W) - 1;
   localparam longint unsigned VIL_CEIL   = (64'd1 << VIL_W) - 1;

   typedef struct packed {
      logic [VIL_W-1:0] vil;
      status_type       status;
   } column_result_type;

   column_result_type expected_columns[$];
   longint unsigned   accum;
   longint unsigned   top_liquid;
   int                top_hgt;
   int                floor_m;
   bit                have_top;
   bit                seen_obs;

   // liquid water content in g/m^3, 16 fraction bits
   function automatic longint unsigned liquid_q16(input int dbz);
      longint unsigned mant;
      longint unsigned step;
      longint unsigned base;
      longint unsigned pow10;
      int ceiling;
      int d;
      int decades;
      int rest;
      ceiling = -400 + TABLE_DEPTH - 1;
      if (ceiling > 560) ceiling = 560;
      d = dbz;
      if (d > ceiling) d = ceiling;
      if (d < -400) d = -400;
      decades = (d + 525) / 175;
      rest = (d + 525) % 175;
      mant = UNIT_Q28;
      step = DBZ_STEP;
      for (int b = 0; b < 8; b++) begin
         if (((rest >> b) & 1) != 0) mant = (mant * step + HALF_Q28) >> 28;
         step = (step * step + HALF_Q28) >> 28;
      end
      base = (LWC_GAIN * mant + HALF_Q28) >> 28;
      pow10 = 1;
      repeat (decades) pow10 = pow10 * 10;
      return (base * pow10 + 64'd50000000) / 64'd100000000;
   endfunction

   function automatic longint unsigned add_sat(input longint unsigned acc,
                                               input longint unsigned inc);
      return (acc > ACC_CEIL - inc) ? ACC_CEIL : acc + inc;
   endfunction

   always @(posedge clock) begin : watch
      column_result_type want;
      column_result_type col;
      longint unsigned   cur;
      longint unsigned   vil;
      int                drop;
      if (reset) begin
         expected_columns.delete();
         accum = 0;
         top_liquid = 0;
         top_hgt = 0;
         have_top = 0;
         seen_obs = 0;
         floor_m = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_columns.size() == 0) begin
               $error("column result with none pending: vil_value %0d column_status %0d",
                      rsp_vil_value, rsp_column_status);
               mismatch_count++;
            end else begin
               want = expected_columns.pop_front();
               columns_checked++;
               if (rsp_vil_value !== want.vil) begin
                  $error("vil_value mismatch: expected %0d, actual %0d",
                         want.vil, rsp_vil_value);
                  mismatch_count++;
               end
               if (rsp_column_status !== want.status) begin
                  $error("column_status mismatch: expected %0d, actual %0d",
                         want.status, rsp_column_status);
                  mismatch_count++;
               end
            end
         end

         if (psel && penable && pwrite && pready && paddr[2] == REG_GROUND_HEIGHT)
            floor_m = int'($signed(pwdata[HGT_W-1:0]));

         if (req_valid && !req_stall) begin
            if (req_observed) begin
               seen_obs = 1;
               if (req_good) begin
                  cur = liquid_q16(int'(req_dbz_tenths));
                  if (have_top) begin
                     drop = top_hgt - int'(req_height_m);
                     if (drop < 0) drop = 0;   // rising beam adds nothing
                     accum = add_sat(accum, (top_liquid + cur) * longint'(drop));
                  end
                  top_hgt = int'(req_height_m);
                  top_liquid = cur;
                  have_top = 1;
               end
            end
            if (req_last_sample) begin
               // extend lowest echo down to the floor
               if (have_top && top_hgt > floor_m)
                  accum = add_sat(accum, 2 * top_liquid * longint'(top_hgt - floor_m));
               if (have_top) begin
                  vil = (accum + 4096) >> 13;
                  if (vil > VIL_CEIL) vil = VIL_CEIL;
                  col.vil = vil[VIL_W-1:0];
                  col.status = STATUS_WEATHER;
               end else begin
                  col.vil = '0;
                  col.status = seen_obs ? STATUS_NO_ECHO : STATUS_UNAVAILABLE;
               end
               expected_columns.push_back(col);
               accum = 0;
               top_liquid = 0;
               top_hgt = 0;
               have_top = 0;
               seen_obs = 0;
            end
         end
      end
      open_columns = expected_columns.size();
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Top of the column integrator bench: clock, reset, sample and register
// stimulus, result stalls and the verdict. Needs vil_pkg and vil_column_checker.
module tb
   import vil_pkg::*;
();

   typedef struct packed {
      logic                    observed;
      logic                    good;
      logic signed [DBZ_W-1:0] dbz;
      logic signed [HGT_W-1:0] height;
      logic                    last;
   } sample_type;

   localparam int SAMPLE_W = $bits(sample_type);

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_observed = 1'b0;
   logic                    req_good = 1'b0;
   logic signed [DBZ_W-1:0] req_dbz_tenths = '0;
   logic signed [HGT_W-1:0] req_height_m = '0;
   logic                    req_last_sample = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [VIL_W-1:0]        rsp_vil_value;
   logic [STAT_W-1:0]       rsp_column_status;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_AW-1:0]       paddr = '0;
   logic [CSR_DW-1:0]       pwdata = '0;
   logic [CSR_DW-1:0]       prdata;
   logic                    pready;

   int mismatch_count;
   int open_columns;
   int columns_checked;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int sample_count = 0;

   always #5 clock = ~clock;

   vil_column_integrator i_dut (.*);

   vil_column_checker i_checker (.*);

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

   function automatic sample_type sample_of(input bit obs, input bit good, input int dbz,
                                            input int h, input bit last);
      return '{obs, good, DBZ_W'(dbz), HGT_W'(h), last};
   endfunction

   task automatic drive_sample(input sample_type s);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_observed <= s.observed;
      req_good <= s.good;
      req_dbz_tenths <= s.dbz;
      req_height_m <= s.height;
      req_last_sample <= s.last;
      do @(posedge clock); while (req_stall !== 1'b0);
      sample_count++;
   endtask

   // hold off until every column result is back and the pipe is empty
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (open_columns != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_ground(input int value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {REG_GROUND_HEIGHT, 2'b00};
      pwdata <= CSR_DW'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic send_column(input bit clean);
      sample_type s;
      int n;
      int h;
      n = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      h = $urandom_range(30000, 500);
      for (int i = 0; i < n; i++) begin
         if (clean) begin
            s.observed = ($urandom_range(15) != 0);
            s.good = ($urandom_range(7) != 0);
            if ($urandom_range(15) == 0) s.dbz = DBZ_W'($urandom);
            else s.dbz = DBZ_W'(int'($urandom_range(1560)) - 600);
            if ($urandom_range(19) == 0) s.height = HGT_W'($urandom);
            else s.height = HGT_W'(h);
            s.last = (i == n - 1);
            if ($urandom_range(7) == 0) h = h + int'($urandom_range(1500, 1));
            else h = h - int'($urandom_range(3000));
            if (h < -1000) h = -1000;
            if (h > 30000) h = 30000;
         end else begin
            s = sample_type'(SAMPLE_W'($urandom));
            if (i == n - 1) s.last = 1'b1;
            else if ($urandom_range(3) != 0) s.last = 1'b0;
         end
         drive_sample(s);
      end
   endtask

   task automatic run_random(input int count);
      int goal;
      goal = sample_count + count;
      while (sample_count < goal) send_column($urandom_range(99) < 85);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed columns, ground at its reset value
      sender_idle_pct = 7;
      receiver_stall_pct = 62;
      drive_sample(sample_of(0, 1, 960, 30000, 1));      // unavailable column
      drive_sample(sample_of(1, 0, 960, 500, 0));        // observed, no echo
      drive_sample(sample_of(0, 0, 0, 0, 1));
      drive_sample(sample_of(1, 1, -600, 30000, 1));     // below clamp, extend to floor
      drive_sample(sample_of(1, 1, 960, 30000, 0));      // floor above lowest echo
      drive_sample(sample_of(1, 1, -400, -1000, 1));
      drive_sample(sample_of(1, 1, 350, 100, 0));        // rising beam
      drive_sample(sample_of(1, 1, 400, 5000, 1));
      drive_sample(sample_of(1, 1, 960, 32767, 0));      // output saturates
      drive_sample(sample_of(1, 1, 960, -32768, 1));
      drive_sample(sample_of(1, 1, -1024, -1, 0));
      drive_sample(sample_of(1, 1, 1023, 0, 0));
      drive_sample(sample_of(1, 1, -1, -1, 1));
      drive_sample(sample_of(1, 1, 200, 12000, 0));      // gaps inside a column
      drive_sample(sample_of(1, 0, 900, 9000, 0));
      drive_sample(sample_of(0, 1, 900, 8000, 0));
      drive_sample(sample_of(1, 1, 100, 3000, 1));
      drive_sample(sample_of(1, 1, 0, 0, 1));            // echo at floor, zero VIL
      drive_sample(sample_of(0, 0, 0, 0, 0));
      drive_sample(sample_of(1, 1, 560, 2000, 1));
      drain();

      write_ground(-1000);
      run_random(500);
      drain();

      sender_idle_pct = 62;
      receiver_stall_pct = 7;
      write_ground(30000);
      run_random(500);
      drain();

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      write_ground(int'($urandom_range(31000)) - 1000);
      run_random(250);
      drain();
      run_random(250);
      drain();

      $display("Drove %0d samples; checked %0d column results.", sample_count,
               columns_checked);
      $display("Floors 0, -1000, 30000 and random; mixed stalls; output saturation.");
      if (mismatch_count == 0 && open_columns == 0)
         $display("** vil_column_integrator: PASSED **");
      else
         $display("** vil_column_integrator: FAILED **");
      $finish;
   end

   initial begin
      #5000000;
      $display("** vil_column_integrator: FAILED **");
      $finish;
   end

endmodule
